[rtl/fbsik_pkg.sv]
`default_nettype none

package fbsik_pkg;

    // Port and datapath widths that do not vary
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int ANGLE_W     = 16;
    localparam int QW          = 35;   // sum of two Q32 angles in [0, pi]
    localparam int ZW          = 36;   // signed CORDIC angle accumulator
    localparam int NORM_BITS   = 30;   // normalize limit 2^30
    localparam int PRE_STAGES  = 7;    // geometry stages before the square root
    localparam int SQRT_STAGES = 32;   // one result bit per stage

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM_LOW  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOREARM_LOW    = 3'd4;

    // Register values after reset
    localparam logic [CFG_W-1:0] BASE_LENGTH_RESET = 16'd1920;
    localparam logic [CFG_W-1:0] UPPER_ARM_RESET   = 16'd1920;
    localparam logic [CFG_W-1:0] FOREARM_RESET     = 16'd2880;

    // Angles in Q32 radians
    localparam logic [33:0] PI_Q32      = 34'd13493037705;
    localparam logic [33:0] HALF_PI_Q32 = 34'd6746518852;

    localparam logic [33:0] ATAN_Q32 [12] = '{
        34'd3373259426, 34'd1991351318, 34'd1052175346, 34'd534100635,
        34'd268086748,  34'd134174063,  34'd67103404,   34'd33553749,
        34'd16777131,   34'd8388597,    34'd4194303,    34'd2097152
    };

    // atan(2^-i) in Q32; past the table it is 2^(32-i), and zero from i = 32 on
    function automatic logic [33:0] atan_q32(input int unsigned i);
        logic [33:0] val;
        if (i < 12) begin
            val = ATAN_Q32[i[3:0]];
        end
        else if (i < 32) begin
            val = 34'(1) << (32 - i);
        end
        else begin
            val = '0;
        end
        return val;
    endfunction

    typedef struct packed {
        logic valid;
        logic tag;
    } chain_ctl_t;

    typedef struct packed {
        logic valid;
        logic tag;
        logic reach;
    } chain_stat_t;

endpackage

`default_nettype wire

[rtl/fbsik_chain.sv]
`default_nettype none

module fbsik_chain #(
    parameter int COORD_BITS   = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire fbsik_pkg::chain_ctl_t                        ctl,
    input  wire logic [COORD_BITS:0]                          ax,
    input  wire logic signed [((COORD_BITS > 16) ? COORD_BITS : 16)+1:0] dy,
    input  wire logic [fbsik_pkg::CFG_W-1:0]                  upper_arm,
    input  wire logic [fbsik_pkg::CFG_W-1:0]                  forearm,
    output fbsik_pkg::chain_stat_t                            stat,
    output logic [fbsik_pkg::QW-1:0]                          angle
);
    import fbsik_pkg::*;

    localparam int AXW  = COORD_BITS + 1;
    localparam int DYW  = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int DW   = 2 * DYW;
    localparam int CW   = DW + 2;
    localparam int ORW  = DW + 1;
    localparam int KW   = $clog2(ORW + 1);
    localparam int LW   = ((DYW > 32) ? DYW : 32) + 4;
    localparam int NPRE = PRE_STAGES + SQRT_STAGES;
    localparam int NT   = CORDIC_STEPS + 3;
    localparam int SIDX_REACH = 2;
    localparam int SIDX_CX    = 6;

    typedef struct packed {
        logic                  valid;
        logic                  tag;
        logic                  reach;
        logic [AXW-1:0]        ax;
        logic signed [DYW-1:0] dy;
        logic signed [30:0]    cx;
    } side_t;

    side_t side_in;
    side_t side_reg [NPRE];
    side_t side_last;

    // Stage A: squares of coordinates and arm lengths, arm sum and difference
    logic [16:0]          arm_u, arm_f;
    logic [2*AXW-1:0]     a_axsq_reg;
    logic signed [2*DYW-1:0] a_dysq_next;
    logic [2*DYW-1:0]     a_dysq_reg;
    logic [33:0]          a_usq_reg, a_fsq_reg;
    logic [17:0]          a_sum_reg;
    logic [16:0]          a_dif_reg;

    // Stage B: squared distance and reach bounds
    logic [DW-1:0]        b_d_reg;
    logic [35:0]          b_sumsq_reg;
    logic [33:0]          b_difsq_reg;
    logic [33:0]          b_usq_reg, b_fsq_reg;

    // Stage C: law of cosines numerator
    logic signed [CW-1:0] c_c_reg;
    logic [DW-1:0]        c_d_reg;
    logic [33:0]          c_usq_reg;
    logic                 reach_next;

    // Stage D: common normalize shift
    logic [ORW-1:0]       cm_next, orv;
    logic [KW-1:0]        msb_len, k_next;
    logic [DW-1:0]        d_d_reg;
    logic [33:0]          d_usq_reg;
    logic [ORW-1:0]       d_cm_reg;
    logic                 d_neg_reg;
    logic [KW-1:0]        d_k_reg;

    // Stage E: scaled operands
    logic [DW-1:0]        ds_sh;
    logic [33:0]          us_sh;
    logic [ORW-1:0]       cs_sh;
    logic [29:0]          e_ds_reg, e_us_reg, e_cs_reg;
    logic                 e_neg_reg;

    // Stage F: products
    logic [59:0]          f_p_reg, f_cq_reg;
    logic [29:0]          f_cs_reg;
    logic                 f_neg_reg;

    // Stage G: squared sine term
    logic [61:0]          p4, s2_next;
    logic [61:0]          g_s2_reg;
    logic signed [30:0]   cx_next;

    // Square root, one bit per stage
    logic [63:0]          q_v_reg [SQRT_STAGES];
    logic [63:0]          q_r_reg [SQRT_STAGES];

    // CORDIC lanes: 0 elbow angle, 1 base angle
    chain_stat_t          tctl_reg [NT];
    logic signed [LW-1:0] lane_x [2];
    logic signed [LW-1:0] lane_y [2];
    logic signed [LW-1:0] px [2];
    logic signed [LW-1:0] py [2];
    logic signed [LW-1:0] pm [2];
    logic signed [ZW-1:0] pz [2];
    logic                 h_zero_next [2];
    logic [4:0]           h_sh_next [2];
    logic signed [LW-1:0] h_x_reg [2];
    logic signed [LW-1:0] h_y_reg [2];
    logic signed [ZW-1:0] h_z_reg [2];
    logic                 h_zero_reg [2];
    logic [4:0]           h_sh_reg [2];
    logic signed [LW-1:0] k_x_reg [2][CORDIC_STEPS+1];
    logic signed [LW-1:0] k_y_reg [2][CORDIC_STEPS+1];
    logic signed [ZW-1:0] k_z_reg [2][CORDIC_STEPS+1];
    logic                 k_zero_reg [2][CORDIC_STEPS+1];
    logic [33:0]          zc [2];
    logic [QW-1:0]        ang_reg;

    // Control that travels with each item before the CORDIC
    always_comb
    begin
        side_in       = '0;
        side_in.valid = ctl.valid;
        side_in.tag   = ctl.tag;
        side_in.ax    = ax;
        side_in.dy    = dy;
    end

    assign side_last = side_reg[NPRE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NPRE; j++)
            begin
                side_reg[j] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_in;
            for (int j = 1; j < NPRE; j++)
            begin
                side_t side_nxt;
                side_nxt = side_reg[j-1];
                if (j == SIDX_REACH)
                begin
                    side_nxt.reach = reach_next;
                end
                if (j == SIDX_CX)
                begin
                    side_nxt.cx = cx_next;
                end
                side_reg[j] <= side_nxt;
            end
        end
    end

    // Stage A
    assign arm_u       = {upper_arm, 1'b0};
    assign arm_f       = {forearm, 1'b0};
    assign a_dysq_next = dy * dy;

    always_ff @(posedge clk)
    begin
        a_axsq_reg <= ax * ax;
        a_dysq_reg <= a_dysq_next;
        a_usq_reg  <= arm_u * arm_u;
        a_fsq_reg  <= arm_f * arm_f;
        a_sum_reg  <= 18'(arm_u) + 18'(arm_f);
        a_dif_reg  <= (arm_u > arm_f) ? (arm_u - arm_f) : (arm_f - arm_u);
    end

    // Stage B
    always_ff @(posedge clk)
    begin
        b_d_reg     <= DW'(a_axsq_reg) + DW'(a_dysq_reg);
        b_sumsq_reg <= a_sum_reg * a_sum_reg;
        b_difsq_reg <= a_dif_reg * a_dif_reg;
        b_usq_reg   <= a_usq_reg;
        b_fsq_reg   <= a_fsq_reg;
    end

    // Stage C: distance must be nonzero and within the annulus
    assign reach_next = (b_d_reg != '0) && (b_d_reg <= DW'(b_sumsq_reg))
                        && (b_d_reg >= DW'(b_difsq_reg));

    always_ff @(posedge clk)
    begin
        c_c_reg   <= $signed(CW'(b_d_reg)) + $signed(CW'(b_usq_reg))
                     - $signed(CW'(b_fsq_reg));
        c_d_reg   <= b_d_reg;
        c_usq_reg <= b_usq_reg;
    end

    // Stage D: find the shift that brings all three below 2^30
    always_comb
    begin
        logic signed [CW-1:0] neg_c;
        neg_c   = -c_c_reg;
        cm_next = c_c_reg[CW-1] ? neg_c[ORW-1:0] : c_c_reg[ORW-1:0];
        orv     = ORW'(c_d_reg) | ORW'(c_usq_reg) | cm_next;
        msb_len = '0;
        for (int i = 0; i < ORW; i++)
        begin
            if (orv[i])
            begin
                msb_len = KW'(i + 1);
            end
        end
        k_next = (msb_len > KW'(NORM_BITS)) ? (msb_len - KW'(NORM_BITS)) : '0;
    end

    always_ff @(posedge clk)
    begin
        d_d_reg   <= c_d_reg;
        d_usq_reg <= c_usq_reg;
        d_cm_reg  <= cm_next;
        d_neg_reg <= c_c_reg[CW-1];
        d_k_reg   <= k_next;
    end

    // Stage E
    assign ds_sh = d_d_reg >> d_k_reg;
    assign us_sh = d_usq_reg >> d_k_reg;
    assign cs_sh = d_cm_reg >> d_k_reg;

    always_ff @(posedge clk)
    begin
        e_ds_reg  <= ds_sh[29:0];
        e_us_reg  <= us_sh[29:0];
        e_cs_reg  <= cs_sh[29:0];
        e_neg_reg <= d_neg_reg;
    end

    // Stage F
    always_ff @(posedge clk)
    begin
        f_p_reg   <= e_ds_reg * e_us_reg;
        f_cq_reg  <= e_cs_reg * e_cs_reg;
        f_cs_reg  <= e_cs_reg;
        f_neg_reg <= e_neg_reg;
    end

    // Stage G: clip the squared sine term at zero, restore the cosine sign
    assign p4      = {f_p_reg, 2'b00};
    assign s2_next = (p4 > 62'(f_cq_reg)) ? (p4 - 62'(f_cq_reg)) : '0;
    assign cx_next = f_neg_reg ? -$signed({1'b0, f_cs_reg}) : $signed({1'b0, f_cs_reg});

    always_ff @(posedge clk)
    begin
        g_s2_reg <= s2_next;
    end

    // Integer square root, one bit per stage
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < SQRT_STAGES; j++)
        begin
            logic [63:0] v_in, r_in, bitv;
            v_in = (j == 0) ? 64'(g_s2_reg) : q_v_reg[(j == 0) ? 0 : j-1];
            r_in = (j == 0) ? '0 : q_r_reg[(j == 0) ? 0 : j-1];
            bitv = 64'(1) << (2 * (SQRT_STAGES - 1 - j));
            if (v_in >= r_in + bitv)
            begin
                q_v_reg[j] <= v_in - (r_in + bitv);
                q_r_reg[j] <= (r_in >> 1) + bitv;
            end
            else
            begin
                q_v_reg[j] <= v_in;
                q_r_reg[j] <= r_in >> 1;
            end
        end
    end

    // CORDIC lane inputs
    always_comb
    begin
        lane_y[0] = LW'($signed({1'b0, q_r_reg[SQRT_STAGES-1][30:0]}));
        lane_x[0] = LW'($signed(side_last.cx));
        lane_y[1] = LW'($signed({1'b0, side_last.ax}));
        lane_x[1] = LW'($signed(side_last.dy));
    end

    // Pre-rotate negative x by pi/2, find the normalize shift
    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            h_zero_next[g] = (lane_y[g] == '0) && (lane_x[g] == '0);
            if (lane_x[g][LW-1])
            begin
                px[g] = lane_y[g];
                py[g] = -lane_x[g];
                pz[g] = $signed(ZW'(HALF_PI_Q32));
            end
            else
            begin
                px[g] = lane_x[g];
                py[g] = lane_y[g];
                pz[g] = '0;
            end
            pm[g]        = (px[g] > py[g]) ? px[g] : py[g];
            h_sh_next[g] = '0;
            if (pm[g][LW-1:NORM_BITS] == '0)
            begin
                for (int b = 0; b < NORM_BITS; b++)
                begin
                    if (pm[g][b])
                    begin
                        h_sh_next[g] = 5'(NORM_BITS - b);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 2; g++)
        begin
            h_x_reg[g]    <= px[g];
            h_y_reg[g]    <= py[g];
            h_z_reg[g]    <= pz[g];
            h_zero_reg[g] <= h_zero_next[g];
            h_sh_reg[g]   <= h_sh_next[g];
        end
    end

    // Normalize, then one CORDIC vectoring step per stage
    always_ff @(posedge clk)
    begin
        for (int g = 0; g < 2; g++)
        begin
            k_x_reg[g][0]    <= h_x_reg[g] <<< h_sh_reg[g];
            k_y_reg[g][0]    <= h_y_reg[g] <<< h_sh_reg[g];
            k_z_reg[g][0]    <= h_z_reg[g];
            k_zero_reg[g][0] <= h_zero_reg[g];
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                logic signed [ZW-1:0] az;
                az = $signed(ZW'(atan_q32(i)));
                if (!k_y_reg[g][i][LW-1] && (k_y_reg[g][i] != '0))
                begin
                    k_x_reg[g][i+1] <= k_x_reg[g][i] + (k_y_reg[g][i] >>> i);
                    k_y_reg[g][i+1] <= k_y_reg[g][i] - (k_x_reg[g][i] >>> i);
                    k_z_reg[g][i+1] <= k_z_reg[g][i] + az;
                end
                else
                begin
                    k_x_reg[g][i+1] <= k_x_reg[g][i] - (k_y_reg[g][i] >>> i);
                    k_y_reg[g][i+1] <= k_y_reg[g][i] + (k_x_reg[g][i] >>> i);
                    k_z_reg[g][i+1] <= k_z_reg[g][i] - az;
                end
                k_zero_reg[g][i+1] <= k_zero_reg[g][i];
            end
        end
    end

    // Clamp each angle to [0, pi] and add them
    always_comb
    begin
        for (int g = 0; g < 2; g++)
        begin
            if (k_zero_reg[g][CORDIC_STEPS] || k_z_reg[g][CORDIC_STEPS][ZW-1])
            begin
                zc[g] = '0;
            end
            else if (k_z_reg[g][CORDIC_STEPS] > $signed(ZW'(PI_Q32)))
            begin
                zc[g] = PI_Q32;
            end
            else
            begin
                zc[g] = k_z_reg[g][CORDIC_STEPS][33:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= QW'(zc[0]) + QW'(zc[1]);
    end

    // Control alongside the CORDIC lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NT; j++)
            begin
                tctl_reg[j] <= '0;
            end
        end
        else
        begin
            tctl_reg[0] <= '{valid: side_last.valid, tag: side_last.tag,
                             reach: side_last.reach};
            for (int j = 1; j < NT; j++)
            begin
                tctl_reg[j] <= tctl_reg[j-1];
            end
        end
    end

    assign stat  = tctl_reg[NT-1];
    assign angle = ang_reg;

endmodule

`default_nettype wire

[rtl/five_bar_scara_inverse_kinematics_core.sv]
// Channel   Direction  Handshake               Payload
// command   in         start, busy             target_x, target_y
// result    out        done (one-cycle strobe) reachable, angle_low, angle_high, mirrored
// config    in         cfg_valid, cfg_ready    cfg_index, cfg_data
//
// One target enters per cycle; busy stays low and cfg_ready stays high.
// Each result passes through the 32-stage square root and the CORDIC step pipeline.
// Reset clears all valid bits and loads the default geometry; no clearing pass.
// The receiver cannot stall: done is a strobe and results are never held.
`default_nettype none

module five_bar_scara_inverse_kinematics_core #(
    parameter int COORD_BITS      = 16,
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STEPS    = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic signed [COORD_BITS-1:0]           target_x,
    input  wire logic signed [COORD_BITS-1:0]           target_y,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [fbsik_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fbsik_pkg::CFG_W-1:0]            cfg_data,
    output logic                                        done,
    output logic                                        reachable,
    output logic [fbsik_pkg::ANGLE_W-1:0]               angle_low,
    output logic [fbsik_pkg::ANGLE_W-1:0]               angle_high,
    output logic                                        mirrored
);
    import fbsik_pkg::*;

    localparam int DYW        = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam int RSH        = 32 - ANGLE_FRAC_BITS;
    localparam int PIPE_DEPTH = PRE_STAGES + SQRT_STAGES + CORDIC_STEPS + 3 + 2;

    logic [CFG_W-1:0]             base_length_reg;
    logic [CFG_W-1:0]             upper_arm_high_reg, forearm_high_reg;
    logic [CFG_W-1:0]             upper_arm_low_reg, forearm_low_reg;

    logic                         in_valid_reg;
    logic signed [COORD_BITS-1:0] in_x_reg, in_y_reg;

    logic signed [COORD_BITS:0]   x_ext, x_abs;
    logic [COORD_BITS:0]          ax;
    logic signed [DYW-1:0]        y2, b_ext, dy_low, dy_high;
    chain_ctl_t                   ctl;

    chain_stat_t                  stat_low, stat_high;
    logic [QW-1:0]                ang_low_q, ang_high_q;
    logic [QW:0]                  rnd_low, rnd_high, sh_low, sh_high;
    logic [ANGLE_W-1:0]           out_low_next, out_high_next;
    logic                         ok_next;

    logic                         done_reg, reachable_reg, mirrored_reg;
    logic [ANGLE_W-1:0]           angle_low_reg, angle_high_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers; out-of-range indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_length_reg    <= BASE_LENGTH_RESET;
            upper_arm_high_reg <= UPPER_ARM_RESET;
            forearm_high_reg   <= FOREARM_RESET;
            upper_arm_low_reg  <= UPPER_ARM_RESET;
            forearm_low_reg    <= FOREARM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_BASE_LENGTH:    base_length_reg    <= cfg_data;
                REG_UPPER_ARM_HIGH: upper_arm_high_reg <= cfg_data;
                REG_FOREARM_HIGH:   forearm_high_reg   <= cfg_data;
                REG_UPPER_ARM_LOW:  upper_arm_low_reg  <= cfg_data;
                REG_FOREARM_LOW:    forearm_low_reg    <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Capture the command transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        in_x_reg <= target_x;
        in_y_reg <= target_y;
    end

    // Doubled coordinates relative to each motor
    assign x_ext   = (COORD_BITS + 1)'(in_x_reg);
    assign x_abs   = in_x_reg[COORD_BITS-1] ? -x_ext : x_ext;
    assign ax      = {x_abs[COORD_BITS-1:0], 1'b0};
    assign y2      = DYW'($signed({in_y_reg, 1'b0}));
    assign b_ext   = DYW'($signed({1'b0, base_length_reg}));
    assign dy_low  = y2 + b_ext;
    assign dy_high = b_ext - y2;

    assign ctl.valid = in_valid_reg;
    assign ctl.tag   = in_x_reg[COORD_BITS-1] || (in_x_reg == '0);

    fbsik_chain #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_chain_low (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ax        (ax),
        .dy        (dy_low),
        .upper_arm (upper_arm_low_reg),
        .forearm   (forearm_low_reg),
        .stat      (stat_low),
        .angle     (ang_low_q)
    );

    fbsik_chain #(
        .COORD_BITS   (COORD_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_chain_high (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ax        (ax),
        .dy        (dy_high),
        .upper_arm (upper_arm_high_reg),
        .forearm   (forearm_high_reg),
        .stat      (stat_high),
        .angle     (ang_high_q)
    );

    // Round half up to the output format and saturate; unreachable targets give zero angles
    assign ok_next  = stat_low.reach && stat_high.reach;
    assign rnd_low  = (QW + 1)'(ang_low_q) + ((QW + 1)'(1) << (RSH - 1));
    assign rnd_high = (QW + 1)'(ang_high_q) + ((QW + 1)'(1) << (RSH - 1));
    assign sh_low   = rnd_low >> RSH;
    assign sh_high  = rnd_high >> RSH;

    always_comb
    begin
        out_low_next  = (sh_low > (QW + 1)'({ANGLE_W{1'b1}})) ? {ANGLE_W{1'b1}}
                                                               : sh_low[ANGLE_W-1:0];
        out_high_next = (sh_high > (QW + 1)'({ANGLE_W{1'b1}})) ? {ANGLE_W{1'b1}}
                                                                : sh_high[ANGLE_W-1:0];
        if (!ok_next)
        begin
            out_low_next  = '0;
            out_high_next = '0;
        end
    end

    // Result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stat_low.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        reachable_reg  <= ok_next;
        angle_low_reg  <= out_low_next;
        angle_high_reg <= out_high_next;
        mirrored_reg   <= stat_low.tag;
    end

    assign done       = done_reg;
    assign reachable  = reachable_reg;
    assign angle_low  = angle_low_reg;
    assign angle_high = angle_high_reg;
    assign mirrored   = mirrored_reg;

    // Every command transaction produces its result after the fixed latency
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_DEPTH done)
        else $error("result missing after command");

    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, PIPE_DEPTH))
        else $error("result without command");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reachable) |-> (angle_low == '0) && (angle_high == '0))
        else $error("angles nonzero for unreachable target");

    a_both_chains: assert property (@(posedge clk) disable iff (!rst_n)
        stat_low.valid == stat_high.valid)
        else $error("chain pipelines out of step");

endmodule

`default_nettype wire

[tb/five_bar_scara_inverse_kinematics_checker.sv]
`default_nettype none

module five_bar_scara_inverse_kinematics_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic signed [15:0]              target_x,
    input  wire logic signed [15:0]              target_y,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [fbsik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [fbsik_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                            done,
    input  wire logic                            reachable,
    input  wire logic [fbsik_pkg::ANGLE_W-1:0]   angle_low,
    input  wire logic [fbsik_pkg::ANGLE_W-1:0]   angle_high,
    input  wire logic                            mirrored,
    output int                                   errors,
    output int                                   outstanding,
    output int                                   checked
);
    import fbsik_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC_SHIFT = 32 - 13;
    localparam longint NORM_LIM   = 64'sd1 << NORM_BITS;
    localparam int     STEPS      = 16;

    typedef struct {
        bit                 reach;
        logic [ANGLE_W-1:0] ang_low;
        logic [ANGLE_W-1:0] ang_high;
        bit                 mirror;
    } joint_pose_t;

    joint_pose_t pending_poses[$];

    // Geometry shadow registers
    logic [CFG_W-1:0] base_len, up_hi, fore_hi, up_lo, fore_lo;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint step_atan(int i);
        if (i < 12) return longint'(ATAN_Q32[i]);
        return 64'sd1 << (32 - i);
    endfunction

    // atan2(yv, xv) for yv >= 0, Q32 radians in [0, pi]
    function automatic longint vector_angle(longint yv, longint xv);
        longint x, y, z, m, nx;
        z = 0;
        if (yv == 0 && xv == 0) return 0;
        if (xv < 0) begin
            x = yv;
            y = -xv;
            z = longint'(HALF_PI_Q32);
        end
        else begin
            x = xv;
            y = yv;
        end
        m = (x > y) ? x : y;
        while (m < NORM_LIM) begin
            x = x <<< 1;
            y = y <<< 1;
            m = m <<< 1;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + step_atan(i);
            end
            else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - step_atan(i);
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > longint'(PI_Q32)) z = longint'(PI_Q32);
        return z;
    endfunction

    // One arm chain: reachability and Q32 motor angle
    function automatic bit chain_angle(longint ax, longint dy, longint upper, longint fore,
                                       output longint ang);
        longint d, u, f, sum, dif, c, cm, ds, us, cs, cx;
        longint unsigned p, cq, s2;
        int k;
        ang = 0;
        k = 0;
        d = ax * ax + dy * dy;
        u = upper * 2;
        f = fore * 2;
        sum = u + f;
        dif = (u > f) ? u - f : f - u;
        if (d == 0 || d > sum * sum || d < dif * dif) return 1'b0;
        c = d + u * u - f * f;
        cm = (c < 0) ? -c : c;
        while ((d >> k) >= NORM_LIM || ((u * u) >> k) >= NORM_LIM || (cm >> k) >= NORM_LIM)
            k++;
        ds = d >> k;
        us = (u * u) >> k;
        cs = cm >> k;
        p = 4 * longint'(ds) * longint'(us);
        cq = cs * cs;
        s2 = (p > cq) ? p - cq : 0;
        cx = (c < 0) ? -cs : cs;
        ang = vector_angle(longint'(root_floor(s2)), cx) + vector_angle(ax, dy);
        return 1'b1;
    endfunction

    function automatic logic [ANGLE_W-1:0] round_angle(longint q32);
        longint r;
        r = (q32 + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        if (r > 64'hFFFF) r = 64'hFFFF;
        return r[ANGLE_W-1:0];
    endfunction

    function automatic joint_pose_t solve_pose(longint x, longint y);
        joint_pose_t pose;
        longint ax, b, al, ah;
        bit rl, rh;
        ax = (x < 0) ? -2 * x : 2 * x;
        b = longint'(base_len);
        rl = chain_angle(ax, 2 * y + b, longint'(up_lo), longint'(fore_lo), al);
        rh = chain_angle(ax, b - 2 * y, longint'(up_hi), longint'(fore_hi), ah);
        pose.reach    = rl && rh;
        pose.ang_low  = pose.reach ? round_angle(al) : '0;
        pose.ang_high = pose.reach ? round_angle(ah) : '0;
        pose.mirror   = (x <= 0);
        return pose;
    endfunction

    assign outstanding = pending_poses.size();

    // Track geometry writes, predict accepted targets, check results
    always @(posedge clk or negedge rst_n) begin
        joint_pose_t want;
        if (!rst_n) begin
            base_len <= BASE_LENGTH_RESET;
            up_hi    <= UPPER_ARM_RESET;
            fore_hi  <= FOREARM_RESET;
            up_lo    <= UPPER_ARM_RESET;
            fore_lo  <= FOREARM_RESET;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE_LENGTH:    base_len <= cfg_data;
                    REG_UPPER_ARM_HIGH: up_hi    <= cfg_data;
                    REG_FOREARM_HIGH:   fore_hi  <= cfg_data;
                    REG_UPPER_ARM_LOW:  up_lo    <= cfg_data;
                    REG_FOREARM_LOW:    fore_lo  <= cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
                pending_poses.insert(pending_poses.size(),
                                     solve_pose(longint'(target_x), longint'(target_y)));
            if (done) begin
                checked++;
                if (pending_poses.size() == 0) begin
                    $error("result with no pending transaction");
                    errors++;
                end
                else begin
                    want = pending_poses.pop_front();
                    if (reachable !== want.reach) begin
                        $error("reachable: expected %0d, got %0d", want.reach, reachable);
                        errors++;
                    end
                    if (angle_low !== want.ang_low) begin
                        $error("angle_low: expected %0d, got %0d", want.ang_low, angle_low);
                        errors++;
                    end
                    if (angle_high !== want.ang_high) begin
                        $error("angle_high: expected %0d, got %0d", want.ang_high, angle_high);
                        errors++;
                    end
                    if (mirrored !== want.mirror) begin
                        $error("mirrored: expected %0d, got %0d", want.mirror, mirrored);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

[tb/five_bar_scara_inverse_kinematics_core_tb.sv]
`default_nettype none

module five_bar_scara_inverse_kinematics_core_tb;
    import fbsik_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 80;
    localparam int PHASES = 8;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [15:0]   target_x;
    logic signed [15:0]   target_y;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 done;
    logic                 reachable;
    logic [ANGLE_W-1:0]   angle_low;
    logic [ANGLE_W-1:0]   angle_high;
    logic                 mirrored;
    int                   errors;
    int                   outstanding;
    int                   checked;

    bit idle_on;
    int targets_sent;
    int span;

    five_bar_scara_inverse_kinematics_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .target_x(target_x), .target_y(target_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .reachable(reachable), .angle_low(angle_low),
        .angle_high(angle_high), .mirrored(mirrored)
    );

    five_bar_scara_inverse_kinematics_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .target_x(target_x), .target_y(target_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .reachable(reachable), .angle_low(angle_low),
        .angle_high(angle_high), .mirrored(mirrored),
        .errors(errors), .outstanding(outstanding), .checked(checked)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hold start low through a random gap
    task automatic idle_gap();
        while (idle_on && $urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Issue one target transaction and wait for it to be taken
    task automatic send_target(int x, int y);
        idle_gap();
        start    <= 1'b1;
        target_x <= 16'(x);
        target_y <= 16'(y);
        @(posedge clk);
        while (busy) @(posedge clk);
        targets_sent++;
    endtask

    // Issue one register write transaction; the caller drops valid when done
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        while (idle_on && $urandom_range(99) < 29) begin
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Drop start and wait until every result is back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic set_geometry(int b, int uh, int fh, int ul, int fl);
        int reach_h, reach_l;
        write_reg(REG_BASE_LENGTH, 16'(b));
        write_reg(REG_UPPER_ARM_HIGH, 16'(uh));
        write_reg(REG_FOREARM_HIGH, 16'(fh));
        write_reg(REG_UPPER_ARM_LOW, 16'(ul));
        write_reg(REG_FOREARM_LOW, 16'(fl));
        cfg_valid <= 1'b0;
        reach_h = uh + fh;
        reach_l = ul + fl;
        span = ((reach_h > reach_l) ? reach_h : reach_l) + b / 2 + 16;
        if (span > 32767) span = 32767;
    endtask

    // Mostly points near the workspace, some anywhere in the field range
    task automatic random_targets(int count);
        int x, y;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15) begin
                x = $signed(16'($urandom));
                y = $signed(16'($urandom));
            end
            else begin
                x = $urandom_range(2 * span) - span;
                y = $urandom_range(2 * span) - span;
            end
            send_target(x, y);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        target_x  = '0;
        target_y  = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE_LENGTH;
        cfg_data  = '0;
        idle_on   = 1'b1;
        targets_sent = 0;
        span = 4800 + 960 + 16;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default geometry: extremes, motor positions, axis points, mirroring
        send_target(0, 0);
        send_target(0, 960);
        send_target(0, -960);
        send_target(4800, -960);
        send_target(2000, 0);
        send_target(-2000, 0);
        send_target(0, 3000);
        send_target(0, -3000);
        send_target(1, 1);
        send_target(-1, -1);
        send_target(32767, 32767);
        send_target(-32768, -32768);
        send_target(32767, -32768);
        send_target(-32768, 32767);
        send_target(-32768, 0);
        send_target(0, 32767);
        drain();

        // Motors on one axis with zero upper arms, exact forearm reach
        write_reg(REG_UNUSED, 16'hFFFF);
        set_geometry(0, 0, 3000, 0, 3000);
        send_target(3000, 0);
        send_target(0, 3000);
        send_target(-3000, 0);
        send_target(1800, 2400);
        send_target(1800, -2400);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph != 2);
            case (ph)
                0: set_geometry(1920, 1920, 2880, 1920, 2880);
                1: set_geometry(0, 1000, 1000, 1000, 1000);
                2: set_geometry(65535, 65535, 65535, 65535, 65535);
                3: set_geometry(0, 0, 0, 0, 0);
                default: set_geometry($urandom_range(8000), $urandom_range(6000),
                                      $urandom_range(6000), $urandom_range(6000),
                                      $urandom_range(6000));
            endcase
            if (ph == 2) send_target(32767, 0);
            random_targets((ph == 3) ? 40 : 110);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d targets over %0d geometry settings, %0d results checked.",
                 targets_sent, PHASES + 2, checked);
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Hard stop on a hung run
    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
